>>> hw/rtl/ule_pkg.sv
`default_nettype none

package ule_pkg;

  // Default storage depth of the line buffer
  localparam int unsigned LINE_DEPTH_DEF = 128;

  // Configuration register indexes
  localparam logic CFG_LINE_LENGTH = 1'b0;
  localparam logic CFG_ABORT       = 1'b1;

  // Configuration reset values
  localparam logic [7:0] LINE_LENGTH_RST = 8'd64;
  localparam logic       ABORT_RST       = 1'b0;

  // Terminal byte codes
  localparam logic [7:0] BYTE_BEL    = 8'h07;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_IAC    = 8'hFF;
  localparam logic [7:0] BYTE_C0     = 8'hC0;
  localparam logic [7:0] BYTE_C1     = 8'hC1;
  localparam logic [7:0] LEAD_MIN    = 8'hC2;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] BAD_LO      = 8'hF5;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // Input request
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } in_req_t;

  // Result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [6:0] line_len;
    logic       last;
  } result_t;

  function automatic result_t make_result(kind_e k, logic [7:0] b, logic [6:0] len);
    result_t r;
    r.kind     = k;
    r.out_byte = b;
    r.line_len = len;
    r.last     = 1'b0;
    return r;
  endfunction

  // UTF-8 continuation byte: 10xxxxxx
  function automatic logic is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8_line_editor_unit.sv
`default_nettype none
// UTF-8 terminal line editor.
// Request channel (in_valid_i/in_ready_o, in_req_i): one request per received
// console byte (action 0) or per read of the finished line (action 1).
// Result channel (out_valid_o/out_ready_i, out_rsp_o): zero to three results
// per request, the final one flagged by last. Echoes, BS SP BS, CR LF and the
// line-complete / line-aborted notices all come out here.
// Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): index 0 line_length,
// index 1 abort_on_invalid; write only while the unit is idle.
// Flow: one request at a time. A stored or echoed byte passes through the emit
// state into the result register; a read first does one memory read. Backspace
// makes up to three dependent reads of the line memory. Extra results follow
// one per cycle while the receiver is ready. A request that makes no result
// (dropped byte, TELNET skip) leaves the unit idle.
// Reset clears the counters and restores the config defaults; the line memory
// is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds and the sequencer
// waits; a new request is taken once the final result sits in the register.
module utf8_line_editor_unit #(
  parameter int unsigned LINE_DEPTH = ule_pkg::LINE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ule_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ule_pkg::result_t      out_rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_wdata_i
);

  import ule_pkg::*;

  localparam int unsigned AW    = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Sequencer and counters
  ule_ctrl #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Line buffer
  ule_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ule_line_mem.sv
`default_nettype none

module ule_line_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/ule_ctrl.sv
`default_nettype none

module ule_ctrl #(
  parameter int unsigned LINE_DEPTH = 128,
  parameter int unsigned AW         = $clog2(LINE_DEPTH),
  parameter int unsigned CNT_W      = $clog2(LINE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ule_pkg::in_req_t in_req_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ule_pkg::result_t      out_rsp_o,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_wdata_i,
  // line memory
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [7:0]            mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  wire logic [7:0]       mem_rdata_i
);

  import ule_pkg::*;

  localparam logic [8:0] DEPTH9 = 9'(LINE_DEPTH);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_BS     = 3'd2;
  localparam logic [2:0] ST_BS_CHK = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [CNT_W-1:0] wc_q, wc_d;
  logic [CNT_W-1:0] fin_q, fin_d;
  logic [1:0]       pend_q, pend_d;
  logic [1:0]       skip_q, skip_d;
  logic [7:0]       len_cfg_q;
  logic             abort_q;
  result_t          plan_q [3];
  result_t          plan_d [3];
  logic [1:0]       plan_n_q, plan_n_d;
  logic [1:0]       emit_q, emit_d;
  logic [1:0]       scan_q, scan_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic [7:0]       v;
  logic             v_ctrl_ok;
  logic             invalid;
  logic [1:0]       pend_n;
  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] size_m1;
  logic [CNT_W-1:0] wc_inc;
  logic [CNT_W-1:0] wc_bs;
  logic [CNT_W-1:0] cr_len;
  logic             out_free;
  logic             emit_last;

  // Effective buffer size: line_length saturated to 2..LINE_DEPTH
  always_comb begin
    if (len_cfg_q < 8'd2) begin
      size = CNT_W'(2);
    end else if ({1'b0, len_cfg_q} > DEPTH9) begin
      size = CNT_W'(LINE_DEPTH);
    end else begin
      size = CNT_W'(len_cfg_q);
    end
    size_m1 = size - CNT_W'(1);
  end

  // Byte classification
  assign v         = in_req_i.rx_byte;
  assign v_ctrl_ok = (v == BYTE_CR) || (v == BYTE_LF) || (v == BYTE_BS) ||
                     (v == BYTE_TAB) || (v == BYTE_BEL) || (v == BYTE_ESC);
  assign invalid   = ((v < BYTE_SPACE) && !v_ctrl_ok) ||
                     ((pend_q == 2'd0) && is_cont(v)) ||
                     (v == BYTE_C0) || (v == BYTE_C1) ||
                     ((v >= BAD_LO) && (v != BYTE_IAC));

  // Continuation tracking for a byte that passes the checks
  always_comb begin
    pend_n = pend_q;
    if (pend_q != 2'd0) begin
      pend_n = is_cont(v) ? pend_q - 2'd1 : 2'd0;
    end
    if ((v >= LEAD_MIN) && (v <= LEAD_MAX)) begin
      if (v[7:3] == 5'b11110) begin
        pend_n = 2'd3;
      end else if (v[7:4] == 4'b1110) begin
        pend_n = 2'd2;
      end else begin
        pend_n = 2'd1;
      end
    end
  end

  assign wc_inc    = wc_q + CNT_W'(1);
  assign wc_bs     = wc_q - CNT_W'(1) - CNT_W'(scan_q);
  assign cr_len    = (wc_q > size_m1) ? size_m1 : wc_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (emit_q == plan_n_q - 2'd1);

  // Sequencer: decide on accept, read the store, walk back over continuations, emit
  always_comb begin
    st_d        = st_q;
    wc_d        = wc_q;
    fin_d       = fin_q;
    pend_d      = pend_q;
    skip_d      = skip_q;
    plan_d      = plan_q;
    plan_n_d    = plan_n_q;
    emit_d      = emit_q;
    scan_d      = scan_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(wc_q);
    mem_wdata_o = v;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(in_req_i.read_index);

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        emit_d = 2'd0;
        if (in_valid_i) begin
          if (in_req_i.action) begin
            // read request
            mem_re_o = 1'b1;
            hit_d    = 9'(in_req_i.read_index) < 9'(fin_q);
            st_d     = ST_RD;
          end else if (skip_q != 2'd0) begin
            skip_d = skip_q - 2'd1;
          end else if (invalid) begin
            if (abort_q) begin
              wc_d      = '0;
              pend_d    = 2'd0;
              fin_d     = '0;
              plan_d[0] = make_result(KIND_ABORT, 8'd0, 7'd0);
              plan_n_d  = 2'd1;
              st_d      = ST_EMIT;
            end
          end else begin
            pend_d = pend_n;
            if (((v == BYTE_BS) || (v == BYTE_DEL)) && (wc_q != '0)) begin
              plan_d[0] = make_result(KIND_ECHO, BYTE_BS, 7'd0);
              plan_d[1] = make_result(KIND_ECHO, BYTE_SPACE, 7'd0);
              plan_d[2] = make_result(KIND_ECHO, BYTE_BS, 7'd0);
              plan_n_d  = 2'd3;
              scan_d    = 2'd0;
              st_d      = ST_BS;
            end else if (v == BYTE_CR) begin
              plan_d[0] = make_result(KIND_ECHO, BYTE_CR, 7'd0);
              plan_d[1] = make_result(KIND_ECHO, BYTE_LF, 7'd0);
              plan_d[2] = make_result(KIND_DONE, 8'd0, 7'(cr_len));
              plan_n_d  = 2'd3;
              fin_d     = cr_len;
              wc_d      = '0;
              pend_d    = 2'd0;
              st_d      = ST_EMIT;
            end else if ((v < BYTE_SPACE) || (v == BYTE_DEL)) begin
              // other control byte: dropped
            end else if (v == BYTE_IAC) begin
              skip_d = 2'd2;
            end else begin
              // store and echo
              mem_we_o  = 9'(wc_q) < DEPTH9;
              plan_d[0] = make_result(KIND_ECHO, v, 7'd0);
              st_d      = ST_EMIT;
              if (wc_inc >= size) begin
                plan_d[1] = make_result(KIND_DONE, 8'd0, 7'(size_m1));
                plan_n_d  = 2'd2;
                fin_d     = size_m1;
                wc_d      = '0;
                pend_d    = 2'd0;
              end else begin
                plan_n_d = 2'd1;
                wc_d     = wc_inc;
              end
            end
          end
        end
      end

      ST_RD: begin
        plan_d[0] = make_result(KIND_READ, hit_q ? mem_rdata_i : 8'd0, 7'd0);
        plan_n_d  = 2'd1;
        st_d      = ST_EMIT;
      end

      ST_BS: begin
        // look at up to three trailing bytes, never position zero
        if ((9'(scan_q) + 9'd1 < 9'(wc_q)) && (scan_q != 2'd3)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(wc_bs);
          st_d        = ST_BS_CHK;
        end else begin
          wc_d = wc_bs;
          st_d = ST_EMIT;
        end
      end

      ST_BS_CHK: begin
        if (is_cont(mem_rdata_i)) begin
          scan_d = scan_q + 2'd1;
          st_d   = ST_BS;
        end else begin
          wc_d = wc_bs;
          st_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = plan_q[emit_q];
          out_d.last  = emit_last;
          emit_d      = emit_q + 2'd1;
          if (emit_last) begin
            st_d = ST_IDLE;
          end
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wc_q        <= '0;
      fin_q       <= '0;
      pend_q      <= 2'd0;
      skip_q      <= 2'd0;
      plan_n_q    <= 2'd0;
      emit_q      <= 2'd0;
      scan_q      <= 2'd0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      wc_q        <= wc_d;
      fin_q       <= fin_d;
      pend_q      <= pend_d;
      skip_q      <= skip_d;
      plan_n_q    <= plan_n_d;
      emit_q      <= emit_d;
      scan_q      <= scan_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
    out_q  <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LINE_LENGTH_RST;
      abort_q   <= ABORT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_LENGTH: len_cfg_q <= cfg_wdata_i;
        CFG_ABORT:       abort_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/ule_checker.sv
`default_nettype none

module ule_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_o,
  input  wire ule_pkg::in_req_t in_req_i,
  input  wire logic             out_valid_o,
  input  wire logic             out_ready_i,
  input  wire ule_pkg::result_t out_rsp_o
);

  import ule_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // A read request always produces a result, so the unit goes busy
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.action |=> !in_ready_o)
    else $error("read request did not occupy the unit");

  // Line end and abort close the request and carry no byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.kind == KIND_DONE || out_rsp_o.kind == KIND_ABORT)
    |-> out_rsp_o.last && (out_rsp_o.out_byte == 8'd0))
    else $error("line end result malformed");

  // Only a completed line carries a length
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.kind != KIND_DONE) |-> out_rsp_o.line_len == 7'd0)
    else $error("length on non-completion result");

endmodule

bind utf8_line_editor_unit ule_checker u_ule_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
  import ule_pkg::*;

  // Request waiting for the driver, with an optional hold until replies drain
  typedef struct packed {
    in_req_t req;
    logic    drain;
  } console_req_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_req_t    in_req_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  result_t    out_rsp_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CFG_LINE_LENGTH;
  logic [7:0] cfg_wdata_i = 8'd0;

  utf8_line_editor_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Stimulus and expected replies
  console_req_t console_reqs [$];
  result_t      terminal_replies [$];

  // Shadow of the editor state and its settings
  logic [7:0]  line_copy [LINE_DEPTH_DEF];
  int unsigned wr_count;
  int unsigned utf_left;
  int unsigned iac_skip;
  int unsigned done_len;
  logic [7:0]  cfg_line_length = LINE_LENGTH_RST;
  logic        cfg_abort       = ABORT_RST;

  // Run bookkeeping
  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned replies_seen   = 0;
  int unsigned lines_done     = 0;
  int unsigned lines_aborted  = 0;
  int unsigned reads_seen     = 0;
  int unsigned settings_used  = 1;
  int unsigned err_count      = 0;
  int unsigned tx_idle_pct    = 7;
  int unsigned rx_idle_pct    = 63;

  logic    next_valid;
  in_req_t next_req;

  // Work out the replies that one accepted request causes
  function automatic void predict_replies(in_req_t req);
    result_t     outs [3];
    int          n;
    int unsigned size;
    int unsigned span;
    int unsigned len;
    logic [7:0]  v;
    logic        cont;
    logic        bad;
    logic        stop;
    n = 0;
    size = cfg_line_length;
    if (size < 2) size = 2;
    if (size > LINE_DEPTH_DEF) size = LINE_DEPTH_DEF;
    if (req.action) begin
      v = (req.read_index < done_len) ? line_copy[req.read_index] : 8'h00;
      outs[n] = '{kind: KIND_READ, out_byte: v, line_len: 7'd0, last: 1'b0};
      n++;
    end else begin
      v = req.rx_byte;
      cont = (v[7:6] == 2'b10);
      bad = (v < BYTE_SPACE && v != BYTE_CR && v != BYTE_LF && v != BYTE_BS &&
             v != BYTE_TAB && v != BYTE_BEL && v != BYTE_ESC) ||
            (utf_left == 0 && cont) ||
            v == BYTE_C0 || v == BYTE_C1 || (v >= BAD_LO && v < BYTE_IAC);
      if (iac_skip != 0) begin
        iac_skip--;
      end else if (bad) begin
        // abort mode clears the line, ignore mode drops the byte
        if (cfg_abort) begin
          done_len = 0;
          wr_count = 0;
          utf_left = 0;
          outs[n] = '{kind: KIND_ABORT, out_byte: 8'h00, line_len: 7'd0, last: 1'b0};
          n++;
        end
      end else begin
        // continuation tracking
        if (utf_left != 0) utf_left = cont ? utf_left - 1 : 0;
        if (v >= LEAD_MIN && v <= LEAD_MAX) begin
          if (v[7:3] == 5'b11110) utf_left = 3;
          else if (v[7:4] == 4'b1110) utf_left = 2;
          else utf_left = 1;
        end
        if ((v == BYTE_BS || v == BYTE_DEL) && wr_count != 0) begin
          outs[0] = '{kind: KIND_ECHO, out_byte: BYTE_BS, line_len: 7'd0, last: 1'b0};
          outs[1] = '{kind: KIND_ECHO, out_byte: BYTE_SPACE, line_len: 7'd0, last: 1'b0};
          outs[2] = outs[0];
          n = 3;
          // erase trailing continuation bytes, at most three
          span = 0;
          stop = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (!stop && k + 1 < wr_count && line_copy[wr_count - k - 1][7:6] == 2'b10)
              span = k + 1;
            else
              stop = 1'b1;
          end
          wr_count = wr_count - 1 - span;
        end else if (v == BYTE_CR) begin
          len = (wr_count > size - 1) ? size - 1 : wr_count;
          outs[0] = '{kind: KIND_ECHO, out_byte: BYTE_CR, line_len: 7'd0, last: 1'b0};
          outs[1] = '{kind: KIND_ECHO, out_byte: BYTE_LF, line_len: 7'd0, last: 1'b0};
          outs[2] = '{kind: KIND_DONE, out_byte: 8'h00, line_len: 7'(len), last: 1'b0};
          n = 3;
          done_len = len;
          wr_count = 0;
          utf_left = 0;
        end else if (v < BYTE_SPACE || v == BYTE_DEL) begin
          // other control bytes are dropped
        end else if (v == BYTE_IAC) begin
          iac_skip = 2;
        end else begin
          // store and echo, complete the line when the buffer fills
          if (wr_count < LINE_DEPTH_DEF) line_copy[wr_count] = v;
          wr_count++;
          outs[n] = '{kind: KIND_ECHO, out_byte: v, line_len: 7'd0, last: 1'b0};
          n++;
          if (wr_count >= size) begin
            outs[n] = '{kind: KIND_DONE, out_byte: 8'h00, line_len: 7'(size - 1),
                        last: 1'b0};
            n++;
            done_len = size - 1;
            wr_count = 0;
            utf_left = 0;
          end
        end
      end
    end
    if (n > 0) outs[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) terminal_replies.push_back(outs[i]);
  endfunction

  // Compare one reply with the oldest expectation
  function automatic void check_reply(result_t got);
    result_t want;
    replies_seen++;
    if (terminal_replies.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("ERROR: unexpected reply kind=%0d byte=%02h len=%0d last=%0b",
                 got.kind, got.out_byte, got.line_len, got.last);
    end else begin
      want = terminal_replies.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.line_len !== want.line_len || got.last !== want.last) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: reply %0d: expected kind=%0d byte=%02h len=%0d last=%0b, got kind=%0d byte=%02h len=%0d last=%0b",
                   replies_seen, want.kind, want.out_byte, want.line_len, want.last,
                   got.kind, got.out_byte, got.line_len, got.last);
      end
    end
    if (got.kind == KIND_DONE) lines_done++;
    if (got.kind == KIND_ABORT) lines_aborted++;
    if (got.kind == KIND_READ) reads_seen++;
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      next_valid = in_valid_i;
      next_req   = in_req_i;
      if (in_valid_i && in_ready_o) begin
        predict_replies(in_req_i);
        accepted_total++;
        next_valid = 1'b0;
      end
      if (!next_valid && console_reqs.size() != 0 &&
          !(console_reqs[0].drain && terminal_replies.size() != 0) &&
          $urandom_range(99) >= tx_idle_pct) begin
        next_req   = console_reqs[0].req;
        next_valid = 1'b1;
        void'(console_reqs.pop_front());
      end
      in_valid_i <= next_valid;
      in_req_i   <= next_req;
    end
  end

  // Reply monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_reply(out_rsp_o);
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_req(logic action, logic [7:0] rx, logic [6:0] idx);
    console_req_t item;
    item.req.action     = action;
    item.req.rx_byte    = rx;
    item.req.read_index = idx;
    item.drain          = ($urandom_range(99) < 4);
    console_reqs.push_back(item);
    queued_total++;
  endtask

  task automatic queue_rx_byte(logic [7:0] v);
    queue_req(1'b0, v, 7'($urandom));
  endtask

  task automatic queue_line_read(logic [6:0] idx);
    queue_req(1'b1, 8'($urandom), idx);
  endtask

  // One random token: mostly well-formed text, some noise
  task automatic queue_random_token();
    int unsigned pick;
    int unsigned nconts;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 40) begin
      queue_rx_byte(8'($urandom_range(8'h7E, 8'h20)));
    end else if (pick < 55) begin
      nconts = $urandom_range(3, 1);
      case (nconts)
        1:       lead = 8'($urandom_range(8'hDF, LEAD_MIN));
        2:       lead = 8'($urandom_range(8'hEF, 8'hE0));
        default: lead = 8'($urandom_range(LEAD_MAX, 8'hF0));
      endcase
      queue_rx_byte(lead);
      // now and then a truncated sequence
      if ($urandom_range(9) == 0) nconts = $urandom_range(nconts - 1);
      for (int k = 0; k < nconts; k++) queue_rx_byte({2'b10, 6'($urandom)});
    end else if (pick < 65) begin
      queue_rx_byte($urandom_range(1) ? BYTE_BS : BYTE_DEL);
    end else if (pick < 72) begin
      queue_rx_byte(BYTE_CR);
    end else if (pick < 80) begin
      queue_line_read($urandom_range(1) ? 7'($urandom) : 7'($urandom_range(15)));
    end else if (pick < 85) begin
      queue_rx_byte(BYTE_IAC);
      queue_rx_byte(8'($urandom));
      queue_rx_byte(8'($urandom));
    end else if (pick < 93) begin
      queue_rx_byte(8'($urandom));
    end else begin
      case ($urandom_range(3))
        0:       queue_rx_byte({2'b10, 6'($urandom)});
        1:       queue_rx_byte($urandom_range(1) ? BYTE_C0 : BYTE_C1);
        2:       queue_rx_byte(8'($urandom_range(8'hFE, BAD_LO)));
        default: queue_rx_byte(8'($urandom_range(8'h1F)));
      endcase
    end
  endtask

  // Wait until every request is taken and every reply has come back
  task automatic settle_idle();
    while (accepted_total != queued_total || terminal_replies.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_LINE_LENGTH) cfg_line_length = val;
    else cfg_abort = val[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Main sequence
  logic [7:0] phase_len [9] = '{8'd255, 8'd2, 8'd0, 8'd128, 8'd1, 8'd129, 8'd3, 8'd9, 8'd5};

  initial begin
    int unsigned start_count;
    for (int i = 0; i < LINE_DEPTH_DEF; i++) line_copy[i] = 8'h00;
    wr_count = 0;
    utf_left = 0;
    iac_skip = 0;
    done_len = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: text, UTF-8 of every length, erase, invalid bytes, TELNET skip
    queue_rx_byte(8'h41);
    queue_rx_byte(8'h7E);
    queue_rx_byte(8'hC3);
    queue_rx_byte(8'hA9);
    queue_rx_byte(8'hE2);
    queue_rx_byte(8'h82);
    queue_rx_byte(8'hAC);
    queue_rx_byte(8'hF0);
    queue_rx_byte(8'h9F);
    queue_rx_byte(8'h98);
    queue_rx_byte(8'h80);
    queue_rx_byte(BYTE_DEL);
    queue_rx_byte(BYTE_BS);
    queue_rx_byte(8'h80);
    queue_rx_byte(BYTE_C1);
    queue_rx_byte(BAD_LO);
    queue_rx_byte(8'h01);
    queue_rx_byte(BYTE_ESC);
    queue_rx_byte(BYTE_IAC);
    queue_rx_byte(8'h00);
    queue_rx_byte(8'hFF);
    queue_rx_byte(BYTE_CR);
    queue_rx_byte(BYTE_BS);
    queue_line_read(7'd0);
    queue_line_read(7'd127);
    settle_idle();

    // Directed: abort mode with the smallest buffer
    write_cfg(CFG_ABORT, 8'd1);
    write_cfg(CFG_LINE_LENGTH, 8'd2);
    settings_used++;
    queue_rx_byte(8'h5A);
    queue_line_read(7'd0);
    queue_rx_byte(8'h05);
    queue_line_read(7'd0);
    settle_idle();

    // Random phases: sender idles lightly first, then the receiver, then neither
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 7;
        rx_idle_pct = 63;
      end else if (ph < 6) begin
        tx_idle_pct = 63;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_cfg(CFG_LINE_LENGTH, (ph == 7) ? 8'($urandom_range(24, 2)) : phase_len[ph]);
      write_cfg(CFG_ABORT, 8'($urandom_range(1)));
      settings_used++;
      start_count = queued_total;
      while (queued_total - start_count < 30) queue_random_token();
      settle_idle();
    end

    $display("Run covered %0d requests and %0d replies over %0d settings.",
             accepted_total, replies_seen, settings_used);
    $display("Lines completed %0d, aborted %0d, line reads %0d.",
             lines_done, lines_aborted, reads_seen);
    if (terminal_replies.size() != 0)
      $display("ERROR: %0d replies never arrived", terminal_replies.size());
    if (err_count == 0 && terminal_replies.size() == 0) begin
      $display("** utf8_line_editor_unit: PASSED **");
    end else begin
      $display("** utf8_line_editor_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 300000);
    $display("ERROR: timeout");
    $display("** utf8_line_editor_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/ule_pkg.sv
hw/rtl/ule_line_mem.sv
hw/rtl/ule_ctrl.sv
hw/rtl/utf8_line_editor_unit.sv
hw/rtl/ule_checker.sv
dv/testbench.sv
